// ===== src/ctc_pkg.sv =====
package ctc_pkg;

  // Pixel field layout (RGB565)
  localparam int RED_W   = 5;
  localparam int GREEN_W = 6;
  localparam int BLUE_W  = 5;
  localparam int PIXEL_W = 16;

  // Configuration port
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int SIZE_W     = 11;

  // Output field widths
  localparam int COUNT_W    = 21;
  localparam int CENTROID_W = 11;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RED_MIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_MIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_MAX    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_MAX     = 3'd5;

  // Register reset values
  localparam logic [SIZE_W-1:0]  RST_FRAME_WIDTH  = 11'd640;
  localparam logic [SIZE_W-1:0]  RST_FRAME_HEIGHT = 11'd480;
  localparam logic [RED_W-1:0]   RST_RED_MIN      = 5'd21;
  localparam logic [GREEN_W-1:0] RST_GREEN_MIN    = 6'd10;
  localparam logic [GREEN_W-1:0] RST_GREEN_MAX    = 6'd40;
  localparam logic [BLUE_W-1:0]  RST_BLUE_MAX     = 5'd10;

  // Configuration register set
  typedef struct packed {
    logic [SIZE_W-1:0]  frame_width;
    logic [SIZE_W-1:0]  frame_height;
    logic [RED_W-1:0]   red_min;
    logic [GREEN_W-1:0] green_min;
    logic [GREEN_W-1:0] green_max;
    logic [BLUE_W-1:0]  blue_max;
  } ctc_cfg_t;

  // Frame-end sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START_X,
    ST_WAIT_X,
    ST_START_Y,
    ST_WAIT_Y,
    ST_OUT
  } ctc_state_t;

endpackage

// ===== src/color_threshold_centroid_top.sv =====
// Color blob centroid over an RGB565 pixel stream.
//
// Input channel (in_valid/in_ready/in_pixel): pixels in raster order. The
// block tracks column and row itself from frame_width and frame_height.
// Output channel (out_valid/out_ready/out_*): one item per frame with the
// match count and the truncated mean column and row (-1 when nothing hit).
// Config port (cfg_we/cfg_index/cfg_wdata): single-cycle register writes;
// the user must write only while no frame is in progress (not enforced).
//
// Throughput: one pixel per clock for every pixel but the last of a frame.
// The last pixel starts two divisions on one shared restoring divider that
// resolves one quotient bit per cycle; in_ready stays low until the result
// is registered. A stalled receiver holds the result register; pixels of
// the next frame are still taken, but its own result waits until the
// register is free. Reset (synchronous, rst_n low) restores the default
// thresholds and 640x480 size and clears the position counters and sums.
module color_threshold_centroid_top
  import ctc_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [PIXEL_W-1:0]           in_pixel,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_found,
  output logic [COUNT_W-1:0]           out_match_count,
  output logic signed [CENTROID_W-1:0] out_centroid_x,
  output logic signed [CENTROID_W-1:0] out_centroid_y,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int QUO_W = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int HIT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int SUM_W = QUO_W + HIT_W;

  ctc_cfg_t   cfg_r, cfg_nxt;
  ctc_state_t state_r, state_nxt;

  logic             in_fire, frame_end, clear;
  logic [SUM_W-1:0] col_sum, row_sum;
  logic [HIT_W-1:0] hit_count;
  logic             div_start, div_done, div_sel_y;
  logic [SUM_W-1:0] div_num;
  logic [QUO_W-1:0] div_quo;
  logic [QUO_W-1:0] qx_r, qx_nxt;
  logic             load_out;

  logic                         out_valid_r, out_valid_nxt;
  logic                         found_r;
  logic [COUNT_W-1:0]           count_r;
  logic signed [CENTROID_W-1:0] cx_r, cy_r;

  // Configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  cfg_nxt.frame_width  = SIZE_W'(cfg_wdata);
        REG_FRAME_HEIGHT: cfg_nxt.frame_height = SIZE_W'(cfg_wdata);
        REG_RED_MIN:      cfg_nxt.red_min      = RED_W'(cfg_wdata);
        REG_GREEN_MIN:    cfg_nxt.green_min    = GREEN_W'(cfg_wdata);
        REG_GREEN_MAX:    cfg_nxt.green_max    = GREEN_W'(cfg_wdata);
        REG_BLUE_MAX:     cfg_nxt.blue_max     = BLUE_W'(cfg_wdata);
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= RST_FRAME_WIDTH;
      cfg_r.frame_height <= RST_FRAME_HEIGHT;
      cfg_r.red_min      <= RST_RED_MIN;
      cfg_r.green_min    <= RST_GREEN_MIN;
      cfg_r.green_max    <= RST_GREEN_MAX;
      cfg_r.blue_max     <= RST_BLUE_MAX;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_fire = in_valid && in_ready;

  ctc_pixel_accum #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .SUM_W      (SUM_W),
    .HIT_W      (HIT_W)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .step      (in_fire),
    .clear     (clear),
    .pixel     (in_pixel),
    .frame_end (frame_end),
    .col_sum   (col_sum),
    .row_sum   (row_sum),
    .hit_count (hit_count)
  );

  // Shared divider: column mean first, then row mean
  assign div_num = div_sel_y ? row_sum : col_sum;

  ctc_divider #(
    .NUM_W (SUM_W),
    .DEN_W (HIT_W),
    .QUO_W (QUO_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (hit_count),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && frame_end) begin
          state_nxt = ST_START_X;
        end
      end
      ST_START_X: state_nxt = ST_WAIT_X;
      ST_WAIT_X: begin
        if (div_done) begin
          state_nxt = ST_START_Y;
        end
      end
      ST_START_Y: state_nxt = ST_WAIT_Y;
      ST_WAIT_Y: begin
        if (div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    div_sel_y = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE:    in_ready = 1'b1;
      ST_START_X: div_start = 1'b1;
      ST_WAIT_X:  div_sel_y = 1'b0;
      ST_START_Y: begin
        div_start = 1'b1;
        div_sel_y = 1'b1;
      end
      ST_WAIT_Y:  div_sel_y = 1'b1;
      ST_OUT:     load_out = !out_valid_r || out_ready;
      default:    in_ready = 1'b0;
    endcase
  end

  assign clear = load_out;

  // Column quotient holds while the row division runs
  assign qx_nxt = (state_r == ST_WAIT_X && div_done) ? div_quo : qx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    qx_r <= qx_nxt;
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (load_out) begin
      found_r <= (hit_count != '0);
      count_r <= COUNT_W'(hit_count);
      if (hit_count != '0) begin
        cx_r <= CENTROID_W'(qx_r);
        cy_r <= CENTROID_W'(div_quo);
      end else begin
        cx_r <= '1;
        cy_r <= '1;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = found_r;
  assign out_match_count = count_r;
  assign out_centroid_x  = cx_r;
  assign out_centroid_y  = cy_r;

endmodule

// ===== src/ctc_divider.sv =====
module ctc_divider
  import ctc_pkg::*;
#(
  parameter int NUM_W = 35,
  parameter int DEN_W = 21,
  parameter int QUO_W = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [QUO_W-1:0] quotient
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] den_r, den_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic             fits;

  // One restoring step per cycle; quotient is known to fit in QUO_W bits
  assign fits = (rem_r >= den_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(QUO_W - 1);
      rem_nxt  = dividend;
      den_nxt  = NUM_W'(divisor) << (QUO_W - 1);
      quo_nxt  = '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = rem_r - den_r;
      end
      quo_nxt = QUO_W'({quo_r, fits});
      den_nxt = den_r >> 1;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== src/ctc_pixel_accum.sv =====
module ctc_pixel_accum
  import ctc_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int SUM_W      = 31,
  parameter int HIT_W      = 21
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctc_cfg_t           cfg,
  input  logic               step,
  input  logic               clear,
  input  logic [PIXEL_W-1:0] pixel,
  output logic               frame_end,
  output logic [SUM_W-1:0]   col_sum,
  output logic [SUM_W-1:0]   row_sum,
  output logic [HIT_W-1:0]   hit_count
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WX_W  = ($clog2(MAX_WIDTH + 1) > SIZE_W) ? $clog2(MAX_WIDTH + 1) : SIZE_W;
  localparam int HX_W  = ($clog2(MAX_HEIGHT + 1) > SIZE_W) ? $clog2(MAX_HEIGHT + 1) : SIZE_W;

  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [SUM_W-1:0]   csum_r, csum_nxt;
  logic [SUM_W-1:0]   rsum_r, rsum_nxt;
  logic [HIT_W-1:0]   hit_r, hit_nxt;
  logic [WX_W-1:0]    w_eff;
  logic [HX_W-1:0]    h_eff;
  logic               last_col, last_row, match;
  logic [RED_W-1:0]   red;
  logic [GREEN_W-1:0] green;
  logic [BLUE_W-1:0]  blue;

  // Effective frame size: zero acts as one, oversize clamps to the maximum
  always_comb begin
    if (cfg.frame_width == '0) begin
      w_eff = WX_W'(1);
    end else if (WX_W'(cfg.frame_width) > WX_W'(MAX_WIDTH)) begin
      w_eff = WX_W'(MAX_WIDTH);
    end else begin
      w_eff = WX_W'(cfg.frame_width);
    end
    if (cfg.frame_height == '0) begin
      h_eff = HX_W'(1);
    end else if (HX_W'(cfg.frame_height) > HX_W'(MAX_HEIGHT)) begin
      h_eff = HX_W'(MAX_HEIGHT);
    end else begin
      h_eff = HX_W'(cfg.frame_height);
    end
  end

  assign last_col  = (WX_W'(col_r) >= (w_eff - WX_W'(1)));
  assign last_row  = (HX_W'(row_r) >= (h_eff - HX_W'(1)));
  assign frame_end = last_col && last_row;

  // Color window test
  assign red   = pixel[15:11];
  assign green = pixel[10:5];
  assign blue  = pixel[4:0];
  assign match = (red >= cfg.red_min) && (green >= cfg.green_min) &&
                 (green <= cfg.green_max) && (blue <= cfg.blue_max);

  // Position walk and match accumulation
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    csum_nxt = csum_r;
    rsum_nxt = rsum_r;
    hit_nxt  = hit_r;
    if (clear) begin
      col_nxt  = '0;
      row_nxt  = '0;
      csum_nxt = '0;
      rsum_nxt = '0;
      hit_nxt  = '0;
    end else if (step) begin
      if (match) begin
        csum_nxt = csum_r + SUM_W'(col_r);
        rsum_nxt = rsum_r + SUM_W'(row_r);
        hit_nxt  = hit_r + HIT_W'(1);
      end
      // positions hold at the frame end until the sequencer clears them
      if (!frame_end) begin
        if (last_col) begin
          col_nxt = '0;
          row_nxt = row_r + ROW_W'(1);
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      csum_r <= '0;
      rsum_r <= '0;
      hit_r  <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      csum_r <= csum_nxt;
      rsum_r <= rsum_nxt;
      hit_r  <= hit_nxt;
    end
  end

  assign col_sum   = csum_r;
  assign row_sum   = rsum_r;
  assign hit_count = hit_r;

endmodule
